@@ rtl/core/gvd_pkg.sv @@
`default_nettype none
package gvd_pkg;

    localparam int unsigned LANES       = 4;
    localparam int unsigned VALUE_WIDTH = 32;

    typedef logic [1:0] lane_idx_t;

    typedef struct packed {
        logic [LANES-1:0][VALUE_WIDTH-1:0] values;
        lane_idx_t                         keep_m1;
        logic                              last;
        logic                              truncated;
    } gvd_rec_t;

endpackage
`default_nettype wire

@@ rtl/core/gvd_front.sv @@
`default_nettype none
module gvd_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // data_byte[7:0]
    input  wire logic              s_tlast,   // last_byte
    input  wire logic              q_full,
    output logic                   rec_push,
    output gvd_pkg::gvd_rec_t      rec
);
    import gvd_pkg::*;

    logic                               awaiting_reg, awaiting_next;
    logic [7:0]                         selector_reg, selector_next;
    lane_idx_t                          lane_reg, lane_next;
    logic [1:0]                         pos_reg, pos_next;
    logic [LANES-1:0][VALUE_WIDTH-1:0]  values_reg, values_next;
    logic [LANES-1:0]                   nz_reg, nz_next;

    logic                               accept;
    logic [1:0]                         len_code;
    logic                               lane_end;
    logic                               group_done;
    logic [VALUE_WIDTH-1:0]             shifted;
    logic [LANES-1:0][VALUE_WIDTH-1:0]  values_cur;
    logic [LANES-1:0]                   nz_cur;
    lane_idx_t                          keep_m1;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign len_code = selector_reg[{lane_reg, 1'b0} +: 2];
    assign lane_end = (pos_reg == len_code);
    assign group_done = !awaiting_reg && lane_end && (lane_reg == lane_idx_t'(LANES - 1));
    assign shifted  = {{(VALUE_WIDTH-8){1'b0}}, s_tdata} << {pos_reg, 3'b000};

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (lane_reg == lane_idx_t'(i))
            begin
                values_cur[i] = values_reg[i] | shifted;
                nz_cur[i]     = nz_reg[i] | (s_tdata != 8'h00);
            end
            else
            begin
                values_cur[i] = values_reg[i];
                nz_cur[i]     = nz_reg[i];
            end
        end
    end

    // trailing zero lanes of the final group are dropped, one lane always kept
    always_comb
    begin
        if (!s_tlast || nz_cur[3])
            keep_m1 = 2'd3;
        else if (nz_cur[2])
            keep_m1 = 2'd2;
        else if (nz_cur[1])
            keep_m1 = 2'd1;
        else
            keep_m1 = 2'd0;
    end

    always_comb
    begin
        rec.values    = values_cur;
        rec.keep_m1   = keep_m1;
        rec.last      = s_tlast;
        rec.truncated = !group_done;
        rec_push      = accept && (group_done || s_tlast);
    end

    always_comb
    begin
        awaiting_next = awaiting_reg;
        selector_next = selector_reg;
        lane_next     = lane_reg;
        pos_next      = pos_reg;
        values_next   = values_reg;
        nz_next       = nz_reg;
        if (accept)
        begin
            if (awaiting_reg)
            begin
                selector_next = s_tdata;
                values_next   = '0;
                nz_next       = '0;
                lane_next     = '0;
                pos_next      = '0;
                awaiting_next = s_tlast;
            end
            else
            begin
                values_next = values_cur;
                nz_next     = nz_cur;
                if (lane_end)
                begin
                    pos_next  = '0;
                    lane_next = lane_reg + lane_idx_t'(1);
                end
                else
                begin
                    pos_next = pos_reg + 2'd1;
                end
                if (group_done || s_tlast)
                begin
                    awaiting_next = 1'b1;
                    lane_next     = '0;
                    pos_next      = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b1;
            selector_reg <= '0;
            lane_reg     <= '0;
            pos_reg      <= '0;
            values_reg   <= '0;
            nz_reg       <= '0;
        end
        else
        begin
            awaiting_reg <= awaiting_next;
            selector_reg <= selector_next;
            lane_reg     <= lane_next;
            pos_reg      <= pos_next;
            values_reg   <= values_next;
            nz_reg       <= nz_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/gvd_queue.sv @@
`default_nettype none
module gvd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire gvd_pkg::gvd_rec_t push_rec,
    input  wire logic              pop,
    output gvd_pkg::gvd_rec_t      head,
    output logic                   not_empty,
    output logic                   full
);
    import gvd_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    gvd_rec_t          entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/gvd_back.sv @@
`default_nettype none
module gvd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              raw_mode,
    input  wire gvd_pkg::gvd_rec_t rec,
    input  wire logic              rec_valid,
    output logic                   rec_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,   // value[31:0]
    output logic                   m_tlast,   // last_value
    output logic                   m_tuser    // truncated
);
    import gvd_pkg::*;

    lane_idx_t               lane_reg, lane_next;
    logic [VALUE_WIDTH-1:0]  total_reg, total_next;
    logic                    out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0]  out_value_reg, out_value_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_trunc_reg, out_trunc_next;

    logic                    advance;
    logic                    final_lane;
    logic [VALUE_WIDTH-1:0]  lane_value;
    logic [VALUE_WIDTH-1:0]  result;

    assign advance    = rec_valid && (!out_valid_reg || m_tready);
    assign final_lane = (lane_reg == rec.keep_m1);
    assign lane_value = rec.values[lane_reg];
    assign result     = raw_mode ? lane_value : total_reg + lane_value;
    assign rec_pop    = advance && (rec.truncated || final_lane);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_trunc_reg;

    always_comb
    begin
        lane_next      = lane_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_trunc_next = out_trunc_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (rec.truncated)
            begin
                out_value_next = '0;
                out_last_next  = 1'b1;
                out_trunc_next = 1'b1;
                total_next     = '0;
                lane_next      = '0;
            end
            else
            begin
                out_value_next = result;
                out_last_next  = rec.last && final_lane;
                out_trunc_next = 1'b0;
                total_next     = result;
                if (final_lane)
                begin
                    lane_next = '0;
                    if (rec.last)
                        total_next = '0;
                end
                else
                begin
                    lane_next = lane_reg + lane_idx_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_trunc_reg <= out_trunc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lane_reg      <= lane_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/group_varint_decoder.sv @@
// Throughput: one input byte per cycle unless the queue is full; results leave at one
// per cycle while the sink is ready, up to four a group. A group's record enters the
// queue on the edge that takes its final byte; the registered output stage loads from it.
// The back end's running-sum adder emits one queue-head lane per cycle unless stalled.
// Reset (rst_n, asynchronous, active low): awaits a selector, running total zero,
// queue empty, no output pending, raw mode off.
`default_nettype none
module group_varint_decoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,  // emit_raw_deltas
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,      // data_byte[7:0]
    input  wire logic        s_tlast,      // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,      // value[31:0]
    output logic             m_tlast,      // last_value
    output logic             m_tuser       // truncated
);
    import gvd_pkg::*;

    logic      raw_reg;
    logic      q_full;
    logic      q_not_empty;
    logic      rec_push;
    logic      rec_pop;
    gvd_rec_t  push_rec;
    gvd_rec_t  head_rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            raw_reg <= 1'b0;
        else if (cfg_wr_en)
            raw_reg <= cfg_wr_data;
    end

    gvd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .rec_push (rec_push),
        .rec      (push_rec)
    );

    gvd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_rec  (push_rec),
        .pop       (rec_pop),
        .head      (head_rec),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    gvd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_mode  (raw_reg),
        .rec       (head_rec),
        .rec_valid (q_not_empty),
        .rec_pop   (rec_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rec_push && q_full))
        else $error("record pushed into full queue");

    a_trunc_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 32'd0 && m_tlast)
        else $error("truncated result not zero or not final");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rec_pop |-> q_not_empty)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
module tb_top;

    localparam bit MODE_SUM = 1'b0;
    localparam bit MODE_RAW = 1'b1;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 10;

    typedef struct packed {
        logic [gvd_pkg::VALUE_WIDTH-1:0] value;
        logic                            last;
        logic                            truncated;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    result_t expected_results[$];
    result_t head;

    // decoder state mirror
    bit                              awaiting_sel = 1'b1;
    logic [7:0]                      cur_sel = 8'h00;
    logic [1:0]                      cur_lane = 2'd0;
    logic [1:0]                      cur_pos = 2'd0;
    logic [gvd_pkg::VALUE_WIDTH-1:0] lane_val[gvd_pkg::LANES] = '{default: '0};
    logic [gvd_pkg::VALUE_WIDTH-1:0] total = '0;
    bit                              raw_mode = MODE_SUM;

    int bytes_sent = 0;
    int error_count = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    bit sink_hold_req = 1'b0;

    group_varint_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void expect_result(input result_t r);
        expected_results = {expected_results, r};
    endfunction

    function automatic void close_section();
        awaiting_sel = 1'b1;
        cur_lane = 2'd0;
        cur_pos = 2'd0;
        total = '0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input bit l);
        logic [gvd_pkg::VALUE_WIDTH-1:0] sums[gvd_pkg::LANES];
        logic [1:0]                      len_code;
        int                              keep;
        bit                              done;
        done = 1'b0;
        if (awaiting_sel)
        begin
            cur_sel = b;
            lane_val = '{default: '0};
            cur_lane = 2'd0;
            cur_pos = 2'd0;
            awaiting_sel = 1'b0;
        end
        else
        begin
            len_code = cur_sel[2 * cur_lane +: 2];
            lane_val[cur_lane] |= 32'(b) << (8 * cur_pos);
            if (cur_pos == len_code)
            begin
                cur_pos = 2'd0;
                if (cur_lane == 2'd3)
                    done = 1'b1;
                else
                    cur_lane++;
            end
            else
                cur_pos++;
        end
        if (!done)
        begin
            if (l)
            begin
                expect_result('{value: '0, last: 1'b1, truncated: 1'b1});
                close_section();
            end
            return;
        end
        for (int i = 0; i < gvd_pkg::LANES; i++)
        begin
            total = (raw_mode == MODE_RAW ? '0 : total) + lane_val[i];
            sums[i] = total;
        end
        awaiting_sel = 1'b1;
        cur_lane = 2'd0;
        cur_pos = 2'd0;
        keep = gvd_pkg::LANES;
        if (l)
        begin
            if (raw_mode == MODE_RAW)
                while (keep > 1 && sums[keep - 1] == '0)
                    keep--;
            else
                while (keep > 1 && sums[keep - 2] == sums[gvd_pkg::LANES - 1])
                    keep--;
        end
        for (int i = 0; i < keep; i++)
            expect_result('{value: sums[i], last: l && (i == keep - 1), truncated: 1'b0});
        if (l)
            close_section();
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b, input bit l);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= l;
        do
            @(posedge clk);
        while (!s_tready);
        decode_byte(b, l);
        bytes_sent++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input bit mode);
        wait_drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        raw_mode = mode;
    endtask

    task automatic send_group(input bit final_grp, input bit cut);
        logic [7:0] grp[$];
        logic [7:0] sel;
        bit         zero_lane;
        int         stop;
        sel = 8'($urandom);
        grp = {grp, sel};
        for (int ln = 0; ln < gvd_pkg::LANES; ln++)
        begin
            zero_lane = ($urandom_range(2) == 0);
            for (int k = 0; k <= int'(sel[2 * ln +: 2]); k++)
                grp = {grp, zero_lane ? 8'h00 : pick_byte()};
        end
        stop = cut ? int'($urandom_range(grp.size() - 2)) : grp.size() - 1;
        for (int k = 0; k <= stop; k++)
            push_byte(grp[k], (final_grp || cut) && k == stop);
    endtask

    task automatic send_section(input int n_groups);
        for (int g = 0; g < n_groups; g++)
            send_group(g == n_groups - 1, g == n_groups - 1 && $urandom_range(9) == 0);
    endtask

    task automatic test_truncation();
        push_byte(8'hAA, 1'b1);
        push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h02, 1'b1);
    endtask

    task automatic test_running_sum();
        push_byte(8'h03, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'h02, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b1);
    endtask

    task automatic test_raw_mode();
        set_mode(MODE_RAW);
        push_byte(8'h00, 1'b0);
        push_byte(8'h07, 1'b0); push_byte(8'h09, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b1);
    endtask

    task automatic test_mode_switch();
        push_byte(8'hC0, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h78, 1'b0); push_byte(8'h56, 1'b0);
        push_byte(8'h34, 1'b0); push_byte(8'h12, 1'b0);
        // carry the last raw value into the running sum
        set_mode(MODE_SUM);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b1);
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_hold_req = 1'b1;
        send_section(5);
        wait_drain();
        send_section(2);
    endtask

    task automatic test_random(input int src_pct, input int sink_pct, input int n_bytes);
        int target;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
        begin
            if ($urandom_range(3) == 0)
                set_mode(bit'($urandom_range(1)));
            send_section($urandom_range(1, 3));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected transaction: value %h last %b truncated %b",
                             $time, m_tdata, m_tlast, m_tuser);
                    error_count++;
                end
                else
                begin
                    head = expected_results.pop_front();
                    if (m_tdata !== head.value)
                    begin
                        $display("%0t: value expected %h, got %h", $time, head.value, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== head.last)
                    begin
                        $display("%0t: last_value expected %b, got %b", $time, head.last, m_tlast);
                        error_count++;
                    end
                    if (m_tuser !== head.truncated)
                    begin
                        $display("%0t: truncated expected %b, got %b",
                                 $time, head.truncated, m_tuser);
                        error_count++;
                    end
                end
            end
            if (sink_hold_req)
            begin
                hold_left = HOLD_CYCLES;
                sink_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        src_idle_pct = 33;
        sink_stall_pct = 71;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_truncation();
        test_running_sum();
        test_raw_mode();
        test_mode_switch();
        test_random(33, 71, 70);
        test_random(71, 33, 70);
        test_random(0, 0, 70);
        test_backpressure();
        wait_drain();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
